// ----- src/per_thread_shadow_call_stack_core_assert.svh -----
// assertion macros shared by the shadow call stack modules
`ifndef PER_THREAD_SHADOW_CALL_STACK_CORE_ASSERT_SVH
`define PER_THREAD_SHADOW_CALL_STACK_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define PSCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define PSCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PSCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define PSCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- src/pscs_pkg.sv -----
// shared types and constants of the shadow call stack
`default_nettype none
package pscs_pkg;

  localparam int TID_W       = 32;
  localparam int ADDR_W      = 64;
  localparam int ST_W        = 3;
  localparam int OUT_SLOT_W  = 4;
  localparam int OUT_DEPTH_W = 7;

  localparam logic OP_ENTRY = 1'b0;
  localparam logic OP_EXIT  = 1'b1;

  typedef enum logic [ST_W-1:0] {
    ST_PUSHED     = 3'd0,
    ST_NEW_SLOT   = 3'd1,
    ST_POPPED     = 3'd2,
    ST_IGNORED    = 3'd3,
    ST_STACK_FULL = 3'd4,
    ST_TABLE_FULL = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIND,
    S_DEPTH,
    S_EXEC
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic find;
    logic depth_rd;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic hit;
  } sts_t;

endpackage
`default_nettype wire

// ----- src/pscs_ctrl.sv -----
// sequencer for lookup, depth read, stack read and commit
`default_nettype none
`include "per_thread_shadow_call_stack_core_assert.svh"
module pscs_ctrl (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  pscs_pkg::sts_t   sts,
  output pscs_pkg::cmd_t   cmd
);
  import pscs_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_FIND;
        end
      end
      S_FIND: begin
        cmd.find = 1'b1;
        // unknown threads need no depth or stack read
        state_nxt = sts.hit ? S_DEPTH : S_EXEC;
      end
      S_DEPTH: begin
        cmd.depth_rd = 1'b1;
        state_nxt    = S_EXEC;
      end
      S_EXEC: begin
        cmd.commit = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `PSCS_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted word did not raise busy")
  `PSCS_ASSERT_NOW(a_depth_after_hit, clk, rst_n, state_r == S_DEPTH, $past(state_r == S_FIND) && $past(sts.hit), "depth read without a slot hit")
  `PSCS_ASSERT_NEXT(a_exec_frees, clk, rst_n, state_r == S_EXEC, !busy, "busy held after commit")

endmodule
`default_nettype wire

// ----- src/pscs_dpath.sv -----
// slot table, depth and stack memories, result register
`default_nettype none
`include "per_thread_shadow_call_stack_core_assert.svh"
module pscs_dpath #(
  parameter int THREAD_SLOTS = 16,
  parameter int FRAME_DEPTH  = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  pscs_pkg::cmd_t                     cmd,
  output pscs_pkg::sts_t                     sts,
  input  wire logic                          in_operation,
  input  wire logic [pscs_pkg::TID_W-1:0]    in_thread_id,
  input  wire logic [pscs_pkg::ADDR_W-1:0]   in_func_addr,
  output logic                               out_valid,
  output logic [pscs_pkg::ST_W-1:0]          out_status,
  output logic [pscs_pkg::OUT_SLOT_W-1:0]    out_slot,
  output logic [pscs_pkg::OUT_DEPTH_W-1:0]   out_depth
);
  import pscs_pkg::*;

  localparam int SW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam int CW = $clog2(THREAD_SLOTS + 1);
  localparam int DW = $clog2(FRAME_DEPTH + 1);
  localparam int SD = THREAD_SLOTS * FRAME_DEPTH;
  localparam int AW = (SD > 1) ? $clog2(SD) : 1;

  // captured word
  logic              op_r;
  logic [TID_W-1:0]  tid_r;
  logic [ADDR_W-1:0] addr_r;

  // slot table: thread ids sit in flops, compared in parallel
  logic [TID_W-1:0]        thr_r [THREAD_SLOTS];
  logic [CW-1:0]           slots_used_r;
  logic [THREAD_SLOTS-1:0] match_r;

  logic          hit_r;
  logic [SW-1:0] slot_r;
  logic [AW-1:0] base_r;
  logic [AW-1:0] stk_addr_r;

  logic [DW-1:0]     depth_mem [THREAD_SLOTS];
  logic [ADDR_W-1:0] frame_ram [SD];
  logic [DW-1:0]     cur_depth_r;
  logic [ADDR_W-1:0] top_addr_r;

  logic                   out_valid_r;
  status_t                out_status_r;
  logic [OUT_SLOT_W-1:0]  out_slot_r;
  logic [OUT_DEPTH_W-1:0] out_depth_r;

  // lookup
  logic [THREAD_SLOTS-1:0] match_nxt;
  logic [SW-1:0]           enc;
  logic                    hit;
  logic [SW-1:0]           slot_sel;
  logic [AW-1:0]           base_c;

  // stack address
  logic [DW-1:0]    offset;
  logic [AW+DW-1:0] addr_sum;
  logic [AW-1:0]    stk_rd_addr;

  // commit
  logic          stack_full, table_full;
  logic          stk_we, depth_we, thr_we, used_inc;
  logic [DW-1:0] depth_wval;
  status_t       res_status;
  logic [SW-1:0] res_slot;
  logic [DW-1:0] res_depth;
  logic [SW+OUT_SLOT_W-1:0]  slot_ext;
  logic [DW+OUT_DEPTH_W-1:0] depth_ext;

  always_comb begin
    for (int i = 0; i < THREAD_SLOTS; i++) begin
      match_nxt[i] = (CW'(i) < slots_used_r) && (thr_r[i] == in_thread_id);
    end
  end

  // lowest matching slot wins
  always_comb begin
    enc = '0;
    for (int i = THREAD_SLOTS - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        enc = SW'(i);
      end
    end
    hit      = |match_r;
    slot_sel = hit ? enc : SW'(slots_used_r);
    base_c   = AW'(slot_sel * FRAME_DEPTH);
  end

  assign sts.hit = hit;

  always_comb begin
    offset      = (op_r == OP_EXIT) ? (cur_depth_r - DW'(1)) : cur_depth_r;
    addr_sum    = {{DW{1'b0}}, base_r} + {{AW{1'b0}}, offset};
    stk_rd_addr = addr_sum[AW-1:0];
  end

  always_comb begin
    stack_full = cur_depth_r >= DW'(FRAME_DEPTH);
    table_full = slots_used_r >= CW'(THREAD_SLOTS);
    stk_we     = 1'b0;
    depth_we   = 1'b0;
    thr_we     = 1'b0;
    used_inc   = 1'b0;
    depth_wval = cur_depth_r;
    res_status = ST_IGNORED;
    res_slot   = '0;
    res_depth  = '0;
    if (op_r == OP_ENTRY) begin
      if (hit_r) begin
        res_slot = slot_r;
        if (stack_full) begin
          res_status = ST_STACK_FULL;
          res_depth  = cur_depth_r;
        end else begin
          stk_we     = 1'b1;
          depth_we   = 1'b1;
          depth_wval = cur_depth_r + DW'(1);
          res_status = ST_PUSHED;
          res_depth  = cur_depth_r + DW'(1);
        end
      end else if (table_full) begin
        res_status = ST_TABLE_FULL;
      end else begin
        stk_we     = 1'b1;
        depth_we   = 1'b1;
        thr_we     = 1'b1;
        used_inc   = 1'b1;
        depth_wval = DW'(1);
        res_status = ST_NEW_SLOT;
        res_slot   = slot_r;
        res_depth  = DW'(1);
      end
    end else if (hit_r) begin
      res_slot  = slot_r;
      res_depth = cur_depth_r;
      if ((cur_depth_r != '0) && (top_addr_r == addr_r)) begin
        depth_we   = 1'b1;
        depth_wval = cur_depth_r - DW'(1);
        res_status = ST_POPPED;
        res_depth  = cur_depth_r - DW'(1);
      end
    end
    slot_ext  = {{OUT_SLOT_W{1'b0}}, res_slot};
    depth_ext = {{OUT_DEPTH_W{1'b0}}, res_depth};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_used_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit;
      if (cmd.commit && used_inc) begin
        slots_used_r <= slots_used_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_operation;
      tid_r   <= in_thread_id;
      addr_r  <= in_func_addr;
      match_r <= match_nxt;
    end
    if (cmd.find) begin
      hit_r       <= hit;
      slot_r      <= slot_sel;
      base_r      <= base_c;
      stk_addr_r  <= base_c;
      cur_depth_r <= depth_mem[enc];
    end
    if (cmd.depth_rd) begin
      stk_addr_r <= stk_rd_addr;
      top_addr_r <= frame_ram[stk_rd_addr];
    end
    if (cmd.commit) begin
      if (thr_we) begin
        thr_r[slot_r] <= tid_r;
      end
      if (depth_we) begin
        depth_mem[slot_r] <= depth_wval;
      end
      if (stk_we) begin
        frame_ram[stk_addr_r] <= addr_r;
      end
      out_status_r <= res_status;
      out_slot_r   <= slot_ext[OUT_SLOT_W-1:0];
      out_depth_r  <= depth_ext[OUT_DEPTH_W-1:0];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;
  assign out_depth  = out_depth_r;

  `PSCS_ASSERT_NOW(a_out_after_commit, clk, rst_n, out_valid_r, $past(cmd.commit), "result strobe without commit")
  `PSCS_ASSERT_NOW(a_used_bound, clk, rst_n, 1'b1, slots_used_r <= CW'(THREAD_SLOTS), "slot count past table size")
  `PSCS_ASSERT_NOW(a_new_slot_count, clk, rst_n, out_valid_r && (out_status_r == ST_NEW_SLOT), slots_used_r == $past(slots_used_r) + CW'(1), "new slot without count step")

endmodule
`default_nettype wire

// ----- src/per_thread_shadow_call_stack_core.sv -----
// top level of the per-thread shadow call stack
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------------
//  input    | start / busy       | in_operation, in_thread_id, in_func_addr
//  result   | out_valid (strobe) | out_status, out_slot, out_depth
//
// a word whose thread holds a slot passes compare, slot select with depth read,
// stack read and commit before the next accept; other words skip the stack read
// the result strobe rises the cycle after commit while busy is already low, so
// a new word may be accepted while a result is shown; the receiver cannot stall
// reset clears the controller, the slot count and the strobe; memories are
// left as they are; unwritten entries may be read but their values go unused
`default_nettype none
module per_thread_shadow_call_stack_core #(
  parameter int THREAD_SLOTS = 16,
  parameter int FRAME_DEPTH  = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_operation,
  input  wire logic [pscs_pkg::TID_W-1:0]    in_thread_id,
  input  wire logic [pscs_pkg::ADDR_W-1:0]   in_func_addr,
  output logic                               out_valid,
  output logic [pscs_pkg::ST_W-1:0]          out_status,
  output logic [pscs_pkg::OUT_SLOT_W-1:0]    out_slot,
  output logic [pscs_pkg::OUT_DEPTH_W-1:0]   out_depth
);
  import pscs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pscs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  pscs_dpath #(
    .THREAD_SLOTS (THREAD_SLOTS),
    .FRAME_DEPTH  (FRAME_DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_operation (in_operation),
    .in_thread_id (in_thread_id),
    .in_func_addr (in_func_addr),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_slot     (out_slot),
    .out_depth    (out_depth)
  );

endmodule
`default_nettype wire

// ----- bench/per_thread_shadow_call_stack_core_tb.sv -----
// self-checking bench for the per-thread shadow call stack core
module per_thread_shadow_call_stack_core_tb;
  import pscs_pkg::*;

  localparam int THREAD_SLOTS = 16;
  localparam int FRAME_DEPTH  = 64;
  localparam int RUN_WORDS    = 550;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int TAIL_CYCLES  = 20;

  typedef struct {
    logic              op;
    logic [TID_W-1:0]  tid;
    logic [ADDR_W-1:0] addr;
    int                gap;
    bit                hold;
  } call_word_t;

  typedef struct {
    status_t                status;
    logic [OUT_SLOT_W-1:0]  slot;
    logic [OUT_DEPTH_W-1:0] depth;
  } call_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic                   in_operation = OP_ENTRY;
  logic [TID_W-1:0]       in_thread_id = '0;
  logic [ADDR_W-1:0]      in_func_addr = '0;
  logic                   out_valid;
  logic [ST_W-1:0]        out_status;
  logic [OUT_SLOT_W-1:0]  out_slot;
  logic [OUT_DEPTH_W-1:0] out_depth;

  per_thread_shadow_call_stack_core #(
    .THREAD_SLOTS(THREAD_SLOTS),
    .FRAME_DEPTH (FRAME_DEPTH)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_operation(in_operation),
    .in_thread_id(in_thread_id),
    .in_func_addr(in_func_addr),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_slot    (out_slot),
    .out_depth   (out_depth)
  );

  // predicted copy of the thread table and stacks
  logic [TID_W-1:0]  slot_owner [THREAD_SLOTS];
  int                slot_level [THREAD_SLOTS];
  logic [ADDR_W-1:0] shadow_mem [THREAD_SLOTS][FRAME_DEPTH];
  int                slots_taken = 0;

  call_word_t   pending_words[$];
  call_result_t expected_results[$];
  int           errors = 0;
  int           cycles = 0;
  int           idle_cnt = 0;
  int           status_seen [6];
  bit           burst = 1'b0;

  // generator view of each pool thread's stack, used to build matching exits
  logic [TID_W-1:0]  pool_tid [THREAD_SLOTS];
  logic [ADDR_W-1:0] gen_mem [THREAD_SLOTS][FRAME_DEPTH];
  int                gen_level [THREAD_SLOTS];

  function automatic call_result_t shadow_stack_step(call_word_t w);
    call_result_t r;
    bit hit;
    int s;
    int d;
    hit = 1'b0;
    s = 0;
    for (int i = 0; i < THREAD_SLOTS; i++) begin
      if (!hit && i < slots_taken && slot_owner[i] == w.tid) begin
        hit = 1'b1;
        s = i;
      end
    end
    r = '{ST_IGNORED, '0, '0};
    if (w.op == OP_ENTRY) begin
      if (hit) begin
        d = slot_level[s];
        if (d >= FRAME_DEPTH) begin
          r = '{ST_STACK_FULL, 4'(s), 7'(d)};
        end else begin
          shadow_mem[s][d] = w.addr;
          slot_level[s] = d + 1;
          r = '{ST_PUSHED, 4'(s), 7'(d + 1)};
        end
      end else if (slots_taken >= THREAD_SLOTS) begin
        r = '{ST_TABLE_FULL, '0, '0};
      end else begin
        s = slots_taken;
        slot_owner[s] = w.tid;
        shadow_mem[s][0] = w.addr;
        slot_level[s] = 1;
        slots_taken = s + 1;
        r = '{ST_NEW_SLOT, 4'(s), 7'd1};
      end
    end else if (hit) begin
      d = slot_level[s];
      if (d > 0 && shadow_mem[s][d-1] == w.addr) begin
        slot_level[s] = d - 1;
        r = '{ST_POPPED, 4'(s), 7'(d - 1)};
      end else begin
        r = '{ST_IGNORED, 4'(s), 7'(d)};
      end
    end
    return r;
  endfunction

  task automatic add_word(input logic op, input logic [TID_W-1:0] tid,
                          input logic [ADDR_W-1:0] addr, input bit hold);
    call_word_t w;
    w.op   = op;
    w.tid  = tid;
    w.addr = addr;
    w.gap  = burst ? 0 : $urandom_range(0, 9);
    w.hold = hold;
    pending_words.push_back(w);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // driver: a word moves at an edge where start is high and busy is low
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_results.push_back(shadow_stack_step('{in_operation, in_thread_id,
                                                      in_func_addr, 0, 1'b0}));
      end
      if (!start || !busy) begin
        if (pending_words.size() == 0) begin
          start <= 1'b0;
        end else if (idle_cnt < pending_words[0].gap) begin
          idle_cnt <= idle_cnt + 1;
          start <= 1'b0;
        end else if (pending_words[0].hold && expected_results.size() != 0) begin
          start <= 1'b0;
        end else begin
          in_operation <= pending_words[0].op;
          in_thread_id <= pending_words[0].tid;
          in_func_addr <= pending_words[0].addr;
          start <= 1'b1;
          idle_cnt <= 0;
          void'(pending_words.pop_front());
        end
      end
    end
  end

  // monitor: results are strobes, checked against the oldest prediction
  always @(posedge clk) begin
    call_result_t e;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got status %0d slot %0d depth %0d",
                 $time, out_status, out_slot, out_depth);
      end else begin
        e = expected_results.pop_front();
        if (out_status < 6) status_seen[out_status]++;
        if (out_status !== e.status || out_slot !== e.slot || out_depth !== e.depth) begin
          errors++;
          $display("%0t: mismatch, expected status %0d slot %0d depth %0d, got %0d %0d %0d",
                   $time, e.status, e.slot, e.depth, out_status, out_slot, out_depth);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int k;
    int n;
    logic [TID_W-1:0]  t;
    logic [ADDR_W-1:0] a;
    bit clash;
    for (int i = 0; i < 6; i++) status_seen[i] = 0;

    // pool of threads: both extremes plus distinct random ids
    pool_tid[0] = '0;
    pool_tid[1] = '1;
    for (int i = 2; i < THREAD_SLOTS; i++) begin
      do begin
        t = $urandom;
        clash = 1'b0;
        for (int j = 0; j < i; j++) if (pool_tid[j] == t) clash = 1'b1;
      end while (clash);
      pool_tid[i] = t;
    end

    // directed: empty table, mismatch, empty pop, extremes, table fill
    add_word(OP_EXIT,  pool_tid[0], '0, 1'b0);
    add_word(OP_ENTRY, pool_tid[0], '0, 1'b0);
    add_word(OP_EXIT,  pool_tid[0], 64'd1, 1'b0);
    add_word(OP_EXIT,  pool_tid[0], '0, 1'b0);
    add_word(OP_EXIT,  pool_tid[0], '0, 1'b0);
    add_word(OP_ENTRY, pool_tid[1], '1, 1'b0);
    add_word(OP_ENTRY, pool_tid[1], 64'h5555_5555_5555_5555, 1'b0);
    add_word(OP_EXIT,  pool_tid[1], 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
    add_word(OP_EXIT,  pool_tid[1], 64'h5555_5555_5555_5555, 1'b0);
    gen_level[0] = 0;
    gen_level[1] = 1;
    gen_mem[1][0] = '1;
    for (int i = 2; i < THREAD_SLOTS; i++) begin
      a = {$urandom, $urandom};
      add_word(OP_ENTRY, pool_tid[i], a, 1'b0);
      gen_mem[i][0] = a;
      gen_level[i] = 1;
    end
    n = 9 + THREAD_SLOTS - 2;

    while (n < RUN_WORDS) begin
      if (n % 60 == 0) burst = ($urandom_range(0, 2) == 0);
      k = $urandom_range(0, THREAD_SLOTS - 1);
      if (n == 60 || n == 330) begin
        // deep call chain on one thread until the stack overflows, then unwind
        while (gen_level[k] < FRAME_DEPTH) begin
          a = {$urandom, $urandom};
          add_word(OP_ENTRY, pool_tid[k], a, 1'b0);
          gen_mem[k][gen_level[k]] = a;
          gen_level[k]++;
          n++;
        end
        for (int i = 0; i < 3; i++) begin
          add_word(OP_ENTRY, pool_tid[k], {$urandom, $urandom}, 1'b0);
          n++;
        end
        while (gen_level[k] > 0) begin
          gen_level[k]--;
          add_word(OP_EXIT, pool_tid[k], gen_mem[k][gen_level[k]], 1'b0);
          n++;
        end
      end else begin
        case ($urandom_range(0, 19))
          0, 1: begin
            add_word(OP_EXIT, pool_tid[k], {$urandom, $urandom}, n % 100 == 0);
          end
          2, 3: begin
            do begin
              t = $urandom;
              clash = 1'b0;
              for (int j = 0; j < THREAD_SLOTS; j++) if (pool_tid[j] == t) clash = 1'b1;
            end while (clash);
            add_word(1'($urandom_range(0, 1)), t, {$urandom, $urandom}, n % 100 == 0);
          end
          default: begin
            if (gen_level[k] < FRAME_DEPTH &&
                (gen_level[k] == 0 || $urandom_range(0, 99) < 55)) begin
              // recursion reuses the current top address now and then
              a = (gen_level[k] > 0 && $urandom_range(0, 7) == 0) ?
                  gen_mem[k][gen_level[k]-1] : {$urandom, $urandom};
              add_word(OP_ENTRY, pool_tid[k], a, n % 100 == 0);
              gen_mem[k][gen_level[k]] = a;
              gen_level[k]++;
            end else begin
              gen_level[k]--;
              add_word(OP_EXIT, pool_tid[k], gen_mem[k][gen_level[k]], n % 100 == 0);
            end
          end
        endcase
        n++;
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_words.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("words checked: %0d pushed, %0d new slot, %0d popped, %0d ignored exits,",
             status_seen[ST_PUSHED], status_seen[ST_NEW_SLOT], status_seen[ST_POPPED],
             status_seen[ST_IGNORED]);
    $display("  %0d stack full, %0d table full refusals, %0d mismatches",
             status_seen[ST_STACK_FULL], status_seen[ST_TABLE_FULL], errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- per_thread_shadow_call_stack_core.f -----
+incdir+src
src/pscs_pkg.sv
src/pscs_ctrl.sv
src/pscs_dpath.sv
src/per_thread_shadow_call_stack_core.sv
bench/per_thread_shadow_call_stack_core_tb.sv
